// File: rtl/core/olars_pkg.sv
// shared types and constants of the ordered list block
// used by olars_ctrl, olars_dp and the top level; no dependencies
package olars_pkg;

  localparam int OPC_W = 2;
  localparam int VAL_IN_W = 32;
  localparam int STS_W = 2;
  localparam int CNT_W = 5;

  localparam logic [OPC_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STS_W-1:0] RES_OK        = 2'd0;
  localparam logic [STS_W-1:0] RES_FULL      = 2'd1;
  localparam logic [STS_W-1:0] RES_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             append_wr;
    logic             shift_wr;
    logic             idx_inc;
    logic             dec_total;
    logic             set_res;
    logic             pos_hit;
    logic [STS_W-1:0] res_status;
    logic             out_load;
  } olars_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
    logic end_shift;
    logic out_free;
  } olars_sts_t;

endpackage

// File: rtl/core/ordered_list_append_remove_search.sv
// one request at a time: new requests are held off while the walk over the entry memory runs;
// the next request is taken at the edge where the previous result can first be taken
// the result register lets the next request enter while a result waits to be taken
// reset: asynchronous, clears the list to empty; entry memory has no reset
module ordered_list_append_remove_search import olars_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [OPC_W-1:0]           opcode_i,
  input  logic signed [VAL_IN_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STS_W-1:0]           status_o,
  output logic [CNT_W-1:0]           position_o,
  output logic [CNT_W-1:0]           entry_count_o
);

  olars_cmd_t cmd;
  olars_sts_t sts;

  olars_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olars_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// File: rtl/core/olars_ctrl.sv
// controller state machine of the ordered list: sequences append, scan and shift
// depends on olars_pkg
module olars_ctrl import olars_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OPC_W-1:0] opcode_i,
  input  olars_sts_t       sts_i,
  output olars_cmd_t       cmd_o
);

  ctl_state_e       state_q, state_d;
  logic [OPC_W-1:0] op_q, op_d;
  logic             accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign op_d       = accept ? opcode_i : op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_APPEND;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if ((opcode_i == OP_REMOVE || opcode_i == OP_SEARCH) && !sts_i.empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          state_d = (op_q == OP_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (sts_i.end_shift) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (opcode_i)
            OP_APPEND: begin
              cmd_o.set_res = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = RES_FULL;
              end else begin
                cmd_o.append_wr  = 1'b1;
                cmd_o.res_status = RES_OK;
              end
            end
            OP_REMOVE, OP_SEARCH: begin
              if (sts_i.empty) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = RES_NOT_FOUND;
              end
            end
            default: begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = RES_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          if (op_q == OP_REMOVE) begin
            cmd_o.idx_inc = 1'b1;
          end else begin
            cmd_o.set_res    = 1'b1;
            cmd_o.pos_hit    = 1'b1;
            cmd_o.res_status = RES_OK;
          end
        end else if (sts_i.last) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = RES_NOT_FOUND;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.end_shift) begin
          cmd_o.dec_total  = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = RES_OK;
        end else begin
          cmd_o.shift_wr = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

`ifndef SYNTHESIS
  // gap closing only ever follows a remove
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (op_q == OP_REMOVE))
    else $error("shift walk without a remove request");

  // result register is never overwritten while still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while previous one still waits");

  // a scan only runs over a list that holds entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !sts_i.empty)
    else $error("scan over an empty list");
`endif

endmodule

// File: rtl/core/olars_dp.sv
// datapath of the ordered list: entry memory, entry count, walk index, result register
// depends on olars_pkg
module olars_dp import olars_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [VAL_IN_W-1:0] value_i,
  input  olars_cmd_t                 cmd_i,
  output olars_sts_t                 sts_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STS_W-1:0]           status_o,
  output logic [CNT_W-1:0]           position_o,
  output logic [CNT_W-1:0]           entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data_q;
  logic [VALUE_WIDTH-1:0] val_q, val_d, val_in;
  logic [63:0]            val_ext;
  logic [CW-1:0]          total_q, total_d;
  logic [CW-1:0]          idx_q, idx_d, idx_nx, idx_m1;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [STS_W-1:0]       res_status_q, res_status_d;
  logic [CNT_W-1:0]       res_pos_q, res_pos_d;
  logic [31:0]            pos_ext, total_ext;
  logic                   out_vld_q, out_vld_d;
  logic [STS_W-1:0]       out_status_q;
  logic [CNT_W-1:0]       out_pos_q, out_count_q;

  // only the low bits of the operand take part
  assign val_ext = 64'($unsigned(value_i));
  assign val_in  = val_ext[VALUE_WIDTH-1:0];
  assign val_d   = cmd_i.load ? val_in : val_q;

  assign idx_nx = idx_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);
  assign idx_d  = cmd_i.load ? '0 : (cmd_i.idx_inc ? idx_nx : idx_q);

  always_comb begin
    total_d = total_q;
    if (cmd_i.append_wr) begin
      total_d = total_q + CW'(1);
    end else if (cmd_i.dec_total) begin
      total_d = total_q - CW'(1);
    end
  end

  // read follows the next index so rd_data_q lines up with idx_q
  assign rd_en   = (idx_d < CAP_CW);
  assign rd_addr = idx_d[AW-1:0];
  assign wr_en   = cmd_i.append_wr || cmd_i.shift_wr;
  assign wr_addr = cmd_i.append_wr ? total_q[AW-1:0] : idx_m1[AW-1:0];
  assign wr_data = cmd_i.append_wr ? val_in : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign pos_ext      = 32'(idx_nx);
  assign res_status_d = cmd_i.set_res ? cmd_i.res_status : res_status_q;
  assign res_pos_d    = cmd_i.set_res ? (cmd_i.pos_hit ? pos_ext[CNT_W-1:0] : '0) : res_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      idx_q   <= '0;
    end else begin
      total_q <= total_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
  end

  assign sts_o.full      = (total_q == CAP_CW);
  assign sts_o.empty     = (total_q == '0);
  assign sts_o.match     = (rd_data_q == val_q);
  assign sts_o.last      = (idx_nx >= total_q);
  assign sts_o.end_shift = (idx_q >= total_q);
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

  // result register
  assign total_ext = 32'(total_q);

  always_comb begin
    if (cmd_i.out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_count_q  <= total_ext[CNT_W-1:0];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign position_o    = out_pos_q;
  assign entry_count_o = out_count_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CAP_CW)
    else $error("entry count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append_wr |-> !sts_o.full)
    else $error("append written into a full list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dec_total |-> (!sts_o.empty && $past(cmd_i.shift_wr || cmd_i.idx_inc)))
    else $error("remove finished without a preceding walk");
`endif

endmodule

// File: verif/tb_top.sv
// testbench for ordered_list_append_remove_search: scoreboard class with its own list model
// drives append, remove, search and unused-opcode requests with random gaps and stalls, checks every result
// depends on olars_pkg and the top level of the block
module tb_top;
  import olars_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int RUN_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1000;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
  } list_result_t;

  class list_scoreboard;
    logic [VAL_IN_W-1:0] entries[$];
    list_result_t expected_q[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    function void note_request(logic [OPC_W-1:0] op, logic [VAL_IN_W-1:0] val);
      list_result_t res;
      int hit;
      res.status = RES_OK;
      res.position = '0;
      hit = -1;
      foreach (entries[i]) begin
        if (hit < 0 && entries[i] == val) hit = i;
      end
      case (op)
        OP_APPEND: begin
          if (entries.size() >= LIST_DEPTH) res.status = RES_FULL;
          else entries.push_back(val);
        end
        OP_REMOVE: begin
          if (hit < 0) res.status = RES_NOT_FOUND;
          else entries.delete(hit);
        end
        OP_SEARCH: begin
          if (hit < 0) res.status = RES_NOT_FOUND;
          else res.position = CNT_W'(hit + 1);
        end
        default: ;
      endcase
      res.entry_count = CNT_W'(entries.size());
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [STS_W-1:0] sts, logic [CNT_W-1:0] pos,
                               logic [CNT_W-1:0] cnt);
      list_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: status %0d position %0d count %0d",
               sts, pos, cnt);
        error_count++;
        return;
      end
      exp = expected_q.pop_front();
      if (sts !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, sts);
        error_count++;
      end
      if (pos !== exp.position) begin
        $error("position: expected %0d, actual %0d", exp.position, pos);
        error_count++;
      end
      if (cnt !== exp.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", exp.entry_count, cnt);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OPC_W-1:0]    opcode_i;
  logic [VAL_IN_W-1:0] value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STS_W-1:0]    status_o;
  logic [CNT_W-1:0]    position_o;
  logic [CNT_W-1:0]    entry_count_o;

  list_scoreboard sb;
  logic quiet_mode;
  logic hold_off_request;
  int unsigned cycle_count;

  ordered_list_append_remove_search #(
    .CAPACITY(LIST_DEPTH),
    .VALUE_WIDTH(VAL_IN_W)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .opcode_i(opcode_i),
    .value_i(value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o(status_o),
    .position_o(position_o),
    .entry_count_o(entry_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    if (quiet_mode) return 0;
    return $urandom_range(0, 15);
  endfunction

  // offer one request after a random gap and hold it until taken
  task automatic send_request(input logic [OPC_W-1:0] op, input logic [VAL_IN_W-1:0] val);
    int unsigned gap;
    gap = idle_cycles();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, val);
  endtask

  // result side: random stall before each result, one long hold-off on request
  initial begin
    int unsigned gap;
    forever begin
      gap = idle_cycles();
      if (hold_off_request) begin
        gap = 300;
        hold_off_request = 1'b0;
      end
      @(negedge clk_i);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(status_o, position_o, entry_count_o);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("ordered_list_append_remove_search verification failed");
    $finish;
  end

  initial begin
    logic [VAL_IN_W-1:0] pool[8];
    logic [OPC_W-1:0] op;
    logic [VAL_IN_W-1:0] val;
    logic filling;
    int unsigned pick;

    sb = new();
    quiet_mode = 1'b0;
    hold_off_request = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_APPEND;
    value_i = '0;
    out_stall_i = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list, unused opcode
    send_request(OP_SEARCH, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_UNUSED, 32'hffff_ffff);
    // extremes and a duplicate
    send_request(OP_APPEND, 32'h8000_0000);
    send_request(OP_APPEND, 32'h7fff_ffff);
    send_request(OP_APPEND, 32'hffff_ffff);
    send_request(OP_APPEND, 32'h0000_0000);
    send_request(OP_APPEND, 32'h7fff_ffff);
    send_request(OP_SEARCH, 32'h7fff_ffff);
    send_request(OP_REMOVE, 32'h7fff_ffff);
    send_request(OP_SEARCH, 32'h7fff_ffff);
    send_request(OP_SEARCH, 32'h1234_5678);
    send_request(OP_REMOVE, 32'h1234_5678);
    // fill to capacity, then overflow
    for (int i = 0; i < 12; i++) send_request(OP_APPEND, 32'h5a5a_0000 + i);
    send_request(OP_APPEND, 32'ha5a5_a5a5);
    send_request(OP_SEARCH, 32'h5a5a_000b);
    send_request(OP_REMOVE, 32'h5a5a_000b);
    send_request(OP_REMOVE, 32'h8000_0000);
    send_request(OP_UNUSED, 32'h0000_0001);

    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) pool[i] = $urandom();
    filling = 1'b0;

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) quiet_mode = ($urandom_range(0, 2) == 0);
      if (n == 250) begin
        hold_off_request = 1'b1;
        quiet_mode = 1'b1;
      end
      // let everything drain once before going on
      if (n == 600) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end

      if (sb.entries.size() == LIST_DEPTH) filling = 1'b0;
      else if (sb.entries.size() == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = ~filling;

      pick = $urandom_range(0, 99);
      if (filling) begin
        if (pick < 60) op = OP_APPEND;
        else if (pick < 78) op = OP_REMOVE;
        else if (pick < 95) op = OP_SEARCH;
        else op = OP_UNUSED;
      end else begin
        if (pick < 22) op = OP_APPEND;
        else if (pick < 70) op = OP_REMOVE;
        else if (pick < 95) op = OP_SEARCH;
        else op = OP_UNUSED;
      end

      // mostly values already held or from a small pool, so hits and duplicates are common
      pick = $urandom_range(0, 99);
      if (pick < 15) val = $urandom();
      else if (pick < 45 && sb.entries.size() != 0)
        val = sb.entries[$urandom_range(0, sb.entries.size() - 1)];
      else val = pool[$urandom_range(0, 7)];

      send_request(op, val);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("ordered_list_append_remove_search verification clean");
    end else begin
      $display("ordered_list_append_remove_search verification failed");
    end
    $finish;
  end
endmodule

// File: ordered_list_append_remove_search.f
rtl/core/olars_pkg.sv
rtl/core/olars_ctrl.sv
rtl/core/olars_dp.sv
rtl/core/ordered_list_append_remove_search.sv
verif/tb_top.sv
